@@ rtl/xbr_pkg.sv @@
// Shared types, constants and the window tap table for the 2x pixel scaler.
// No dependencies; imported by xbr_ctrl, xbr_datapath, the top level and the testbench.
package xbr_pkg;

   // sizes
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int PIX_W = 32;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 16;
   localparam int ROW_W = 17;
   localparam int LINE_ROWS = 4;
   localparam int COL_TAPS = 5;
   localparam int WIN_N = 25;
   localparam int DIST_W = 25;
   localparam int SUM_W = 28;
   localparam int PADDR_W = 3;

   // register reset values and register indexes (paddr[2])
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // input slot kinds
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // corners, in decision order
   localparam logic [1:0] CORNER_BR = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_TL = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   // distance slots within one corner
   localparam logic [3:0] SUB_S1_FIRST = 4'd0;
   localparam logic [3:0] SUB_S1_HEAVY = 4'd4;
   localparam logic [3:0] SUB_S2_FIRST = 4'd5;
   localparam logic [3:0] SUB_S2_HEAVY = 4'd9;
   localparam logic [3:0] SUB_NEAR     = 4'd10;
   localparam logic [3:0] SUB_LAST     = 4'd11;

   // block column relative to the current column
   localparam logic [1:0] XSEL_LEFT2 = 2'd0;
   localparam logic [1:0] XSEL_LEFT1 = 2'd1;
   localparam logic [1:0] XSEL_HERE  = 2'd2;

   // window taps: column i (0 = x-2), row j (0 = y-2) at i*5+j
   localparam logic [4:0] T_A0 = 5'd1;
   localparam logic [4:0] T_D0 = 5'd2;
   localparam logic [4:0] T_G0 = 5'd3;
   localparam logic [4:0] T_A1 = 5'd5;
   localparam logic [4:0] T_A  = 5'd6;
   localparam logic [4:0] T_D  = 5'd7;
   localparam logic [4:0] T_G  = 5'd8;
   localparam logic [4:0] T_G5 = 5'd9;
   localparam logic [4:0] T_B1 = 5'd10;
   localparam logic [4:0] T_B  = 5'd11;
   localparam logic [4:0] T_E  = 5'd12;
   localparam logic [4:0] T_H  = 5'd13;
   localparam logic [4:0] T_H5 = 5'd14;
   localparam logic [4:0] T_C1 = 5'd15;
   localparam logic [4:0] T_C  = 5'd16;
   localparam logic [4:0] T_F  = 5'd17;
   localparam logic [4:0] T_I  = 5'd18;
   localparam logic [4:0] T_I5 = 5'd19;
   localparam logic [4:0] T_C4 = 5'd21;
   localparam logic [4:0] T_F4 = 5'd22;
   localparam logic [4:0] T_I4 = 5'd23;

   typedef struct packed {
      logic             mode;
      logic [PIX_W-1:0] pixel;
   } xbr_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] top_left;
      logic [PIX_W-1:0] top_right;
      logic [PIX_W-1:0] bottom_left;
      logic [PIX_W-1:0] bottom_right;
      logic [9:0]       source_column;
      logic [15:0]      source_row;
      logic             last_in_step;
      logic             end_of_frame;
   } xbr_rsp_type;

   typedef struct packed {
      logic [4:0] p;
      logic [4:0] q;
   } xbr_taps_type;

   // controller to datapath
   typedef struct packed {
      logic       take;
      logic       rd_en;
      logic [2:0] rd_k;
      logic       win_load;
      logic       win_pass;
      logic       issue;
      logic [1:0] corner;
      logic [3:0] sub;
      logic       out_load;
      logic [1:0] xsel;
      logic       out_last;
      logic       step;
   } xbr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic kind_ok;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic col_last;
      logic emit_done;
      logic out_free;
   } xbr_sts_type;

   // pixel pair for each distance of each corner decision
   function automatic xbr_taps_type pair_taps(input logic [1:0] corner, input logic [3:0] sub);
      xbr_taps_type t;
      t = '{p: T_E, q: T_E};
      unique case (corner)
         CORNER_BR: begin
            case (sub)
               4'd0:    t = '{p: T_E, q: T_C};
               4'd1:    t = '{p: T_E, q: T_G};
               4'd2:    t = '{p: T_I, q: T_F4};
               4'd3:    t = '{p: T_I, q: T_H5};
               4'd4:    t = '{p: T_H, q: T_F};
               4'd5:    t = '{p: T_H, q: T_D};
               4'd6:    t = '{p: T_H, q: T_I5};
               4'd7:    t = '{p: T_F, q: T_I4};
               4'd8:    t = '{p: T_F, q: T_B};
               4'd9:    t = '{p: T_E, q: T_I};
               4'd10:   t = '{p: T_E, q: T_F};
               4'd11:   t = '{p: T_E, q: T_H};
               default: t = '{p: T_E, q: T_E};
            endcase
         end
         CORNER_TR: begin
            case (sub)
               4'd0:    t = '{p: T_E, q: T_I};
               4'd1:    t = '{p: T_E, q: T_A};
               4'd2:    t = '{p: T_C, q: T_F4};
               4'd3:    t = '{p: T_C, q: T_B1};
               4'd4:    t = '{p: T_B, q: T_F};
               4'd5:    t = '{p: T_B, q: T_D};
               4'd6:    t = '{p: T_B, q: T_C1};
               4'd7:    t = '{p: T_F, q: T_H};
               4'd8:    t = '{p: T_F, q: T_C4};
               4'd9:    t = '{p: T_E, q: T_C};
               4'd10:   t = '{p: T_E, q: T_F};
               4'd11:   t = '{p: T_E, q: T_B};
               default: t = '{p: T_E, q: T_E};
            endcase
         end
         CORNER_TL: begin
            case (sub)
               4'd0:    t = '{p: T_E, q: T_G};
               4'd1:    t = '{p: T_E, q: T_C};
               4'd2:    t = '{p: T_A, q: T_D0};
               4'd3:    t = '{p: T_A, q: T_B1};
               4'd4:    t = '{p: T_B, q: T_D};
               4'd5:    t = '{p: T_B, q: T_F};
               4'd6:    t = '{p: T_B, q: T_A1};
               4'd7:    t = '{p: T_D, q: T_H};
               4'd8:    t = '{p: T_D, q: T_A0};
               4'd9:    t = '{p: T_E, q: T_A};
               4'd10:   t = '{p: T_E, q: T_D};
               4'd11:   t = '{p: T_E, q: T_B};
               default: t = '{p: T_E, q: T_E};
            endcase
         end
         default: begin
            case (sub)
               4'd0:    t = '{p: T_E, q: T_I};
               4'd1:    t = '{p: T_E, q: T_A};
               4'd2:    t = '{p: T_G, q: T_D0};
               4'd3:    t = '{p: T_G, q: T_H5};
               4'd4:    t = '{p: T_H, q: T_D};
               4'd5:    t = '{p: T_H, q: T_F};
               4'd6:    t = '{p: T_H, q: T_G5};
               4'd7:    t = '{p: T_D, q: T_B};
               4'd8:    t = '{p: T_D, q: T_G0};
               4'd9:    t = '{p: T_E, q: T_G};
               4'd10:   t = '{p: T_E, q: T_D};
               4'd11:   t = '{p: T_E, q: T_H};
               default: t = '{p: T_E, q: T_E};
            endcase
         end
      endcase
      return t;
   endfunction

endpackage

@@ rtl/xbr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module xbr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/xbr_datapath.sv @@
// Datapath: registers, counters, line store, 5x5 window, distance pipeline,
// corner decisions and result register. Uses xbr_pkg and xbr_ram.
module xbr_datapath #(
   parameter int MAX_WIDTH = xbr_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  xbr_pkg::xbr_cmd_type          cmd,
   output xbr_pkg::xbr_sts_type          sts,
   input  xbr_pkg::xbr_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output xbr_pkg::xbr_rsp_type          rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [xbr_pkg::PADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata
);
   import xbr_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
   localparam int RAM_DEPTH = LINE_ROWS * MAX_WIDTH;
   localparam int AW = $clog2(RAM_DEPTH);
   localparam int RW = ROW_W + 1;

   // configuration and position
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [CW-1:0]           col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [WW-1:0]           w_ext;
   logic [WW-1:0]           eff_w;
   logic [HEIGHT_REG_W-1:0] eff_h;
   logic                    real_row;
   logic                    csr_wr;
   logic [RW-1:0]           row_next;

   // input and column fetch
   logic [PIX_W-1:0] pix_ff;
   logic             rd_v_ff;
   logic [2:0]       rd_k_ff;
   logic             rd_pix_ff;
   logic [PIX_W-1:0] col_buf_ff [COL_TAPS];
   logic [RW-1:0]    rk;
   logic [RW-1:0]    cl0;
   logic [RW-1:0]    cl;
   logic [RW-1:0]    hmax;
   logic [AW-1:0]    raddr;
   logic [AW-1:0]    waddr;
   logic             we;
   logic [PIX_W-1:0] rdata;

   // window
   logic [PIX_W-1:0] win_ff [WIN_N];

   // distance pipeline
   xbr_taps_type     taps;
   logic             s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff;
   logic [1:0]       s0_cor_ff, s1_cor_ff, s2_cor_ff, s3_cor_ff;
   logic [3:0]       s0_sub_ff, s1_sub_ff, s2_sub_ff, s3_sub_ff;
   logic [PIX_W-1:0] s0_p_ff, s0_q_ff;
   logic [7:0]       dr_ff, dg_ff, db_ff, da_ff;
   logic [17:0]      y_ff;
   logic [16:0]      au_ff, av_ff;
   logic [7:0]       a2_ff;
   logic [DIST_W-1:0] dist_ff;
   logic signed [19:0] u_s, v_s;

   // corner decision
   logic [SUM_W-1:0] s1_ff, s2_ff;
   logic [DIST_W-1:0] d1_ff;
   logic [SUM_W-1:0] heavy;
   logic             edge_hit;
   logic             near_first;
   logic [PIX_W-1:0] nc;
   logic [PIX_W-1:0] qtl_ff, qtr_ff, qbl_ff, qbr_ff;
   logic [PIX_W-1:0] qtl_in, qtr_in, qbl_in, qbr_in;

   // result
   logic             rsp_valid_ff;
   xbr_rsp_type      rsp_ff;
   logic [WW-1:0]    xw;
   logic [ROW_W-1:0] yw;

   function automatic logic [7:0] absdiff(input logic [7:0] x, input logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   // effective frame size
   assign w_ext = WW'(width_ff);
   always_comb begin
      if (w_ext == '0) begin
         eff_w = WW'(1);
      end else if (w_ext > WW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = w_ext;
      end
   end
   assign eff_h    = (height_ff == '0) ? HEIGHT_REG_W'(1) : height_ff;
   assign real_row = row_ff < ROW_W'(eff_h);

   // status
   assign sts.kind_ok  = real_row ? (req_data.mode == MODE_PIXEL) : (req_data.mode == MODE_FLUSH);
   assign sts.row_ge2  = row_ff >= ROW_W'(2);
   assign sts.col_ge1  = col_ff != '0;
   assign sts.col_ge2  = col_ff >= CW'(2);
   assign sts.col_last = WW'(col_ff) == eff_w - WW'(1);
   assign sts.emit_done = s3_v_ff && (s3_sub_ff == SUB_LAST) && (s3_cor_ff == CORNER_BL);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // register port
   assign csr_wr = psel && penable && pwrite;
   always_comb begin
      unique case (paddr[2])
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         default:    prdata = '0;
      endcase
   end

   assign row_next = RW'(row_ff) + RW'(1);

   // configuration and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_wr) begin
         if (paddr[2] == REG_WIDTH) begin
            width_ff <= pwdata[WIDTH_REG_W-1:0];
         end else begin
            height_ff <= pwdata[HEIGHT_REG_W-1:0];
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.step) begin
         if (sts.col_last) begin
            col_ff <= '0;
            if (row_next >= RW'(eff_h) + RW'(2)) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_next[ROW_W-1:0];
            end
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // row of window tap k, clamped to the image
   always_comb begin
      rk   = RW'(row_ff) + RW'(cmd.rd_k);
      cl0  = (rk < RW'(4)) ? '0 : rk - RW'(4);
      hmax = RW'(eff_h) - RW'(1);
      cl   = (cl0 > hmax) ? hmax : cl0;
   end
   assign raddr = AW'(cl[1:0]) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign waddr = AW'(row_ff[1:0]) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign we    = cmd.win_load && real_row;

   xbr_ram #(
      .WIDTH(PIX_W),
      .DEPTH(RAM_DEPTH)
   ) u_line_store (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(pix_ff),
      .re(cmd.rd_en),
      .raddr(raddr),
      .rdata(rdata)
   );

   // input latch and fetch of the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pix_ff <= req_data.pixel;
      end
      rd_k_ff   <= cmd.rd_k;
      rd_pix_ff <= real_row && (cl == RW'(row_ff));
      if (rd_v_ff) begin
         col_buf_ff[rd_k_ff] <= rd_pix_ff ? pix_ff : rdata;
      end
   end

   // window: fill at row start, shift left otherwise; a pass repeats the last column
   always_ff @(posedge clock) begin
      for (int i = 0; i < COL_TAPS; i++) begin
         for (int j = 0; j < COL_TAPS; j++) begin
            if (cmd.win_load) begin
               if (col_ff == '0 || i == COL_TAPS - 1) begin
                  win_ff[i*COL_TAPS+j] <= col_buf_ff[j];
               end else begin
                  win_ff[i*COL_TAPS+j] <= win_ff[(i+1)*COL_TAPS+j];
               end
            end else if (cmd.win_pass && i < COL_TAPS - 1) begin
               win_ff[i*COL_TAPS+j] <= win_ff[(i+1)*COL_TAPS+j];
            end
         end
      end
   end

   // distance pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= cmd.issue;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   assign taps = pair_taps(cmd.corner, cmd.sub);

   always_comb begin
      u_s = 20'sd500 * $signed(20'(db_ff)) - 20'sd169 * $signed(20'(dr_ff))
          - 20'sd331 * $signed(20'(dg_ff));
      v_s = 20'sd500 * $signed(20'(dr_ff)) - 20'sd419 * $signed(20'(dg_ff))
          - 20'sd81 * $signed(20'(db_ff));
   end

   // distance pipeline data: pick, channel differences, YUV terms, weighted sum
   always_ff @(posedge clock) begin
      s0_cor_ff <= cmd.corner;
      s0_sub_ff <= cmd.sub;
      s0_p_ff   <= win_ff[taps.p];
      s0_q_ff   <= win_ff[taps.q];
      s1_cor_ff <= s0_cor_ff;
      s1_sub_ff <= s0_sub_ff;
      dr_ff <= absdiff(s0_p_ff[7:0],   s0_q_ff[7:0]);
      dg_ff <= absdiff(s0_p_ff[15:8],  s0_q_ff[15:8]);
      db_ff <= absdiff(s0_p_ff[23:16], s0_q_ff[23:16]);
      da_ff <= absdiff(s0_p_ff[31:24], s0_q_ff[31:24]);
      s2_cor_ff <= s1_cor_ff;
      s2_sub_ff <= s1_sub_ff;
      y_ff  <= 18'(dr_ff) * 18'd299 + 18'(dg_ff) * 18'd587 + 18'(db_ff) * 18'd114;
      au_ff <= u_s[19] ? 17'(-u_s) : 17'(u_s);
      av_ff <= v_s[19] ? 17'(-v_s) : 17'(v_s);
      a2_ff <= da_ff;
      s3_cor_ff <= s2_cor_ff;
      s3_sub_ff <= s2_sub_ff;
      dist_ff <= DIST_W'(y_ff) * DIST_W'(48) + DIST_W'(au_ff) * DIST_W'(7)
               + DIST_W'(av_ff) * DIST_W'(6) + DIST_W'(a2_ff) * DIST_W'(48000);
   end

   // edge sums per corner
   assign heavy = SUM_W'(dist_ff) << 2;
   always_ff @(posedge clock) begin
      if (s3_v_ff) begin
         unique case (s3_sub_ff)
            SUB_S1_FIRST: s1_ff <= SUM_W'(dist_ff);
            SUB_S1_HEAVY: s1_ff <= s1_ff + heavy;
            SUB_S2_FIRST: s2_ff <= SUM_W'(dist_ff);
            SUB_S2_HEAVY: s2_ff <= s2_ff + heavy;
            SUB_NEAR:     d1_ff <= dist_ff;
            SUB_LAST:     d1_ff <= d1_ff;
            default: begin
               if (s3_sub_ff < SUB_S1_HEAVY) begin
                  s1_ff <= s1_ff + SUM_W'(dist_ff);
               end else begin
                  s2_ff <= s2_ff + SUM_W'(dist_ff);
               end
            end
         endcase
      end
   end

   // corner decision; later corners overwrite earlier ones
   assign edge_hit   = s1_ff < s2_ff;
   assign near_first = d1_ff <= dist_ff;
   always_comb begin
      qtl_in = qtl_ff;
      qtr_in = qtr_ff;
      qbl_in = qbl_ff;
      qbr_in = qbr_ff;
      nc     = win_ff[T_E];
      unique case (s3_cor_ff)
         CORNER_BR: begin
            nc = near_first ? win_ff[T_F] : win_ff[T_H];
            if (edge_hit) begin
               qbr_in = nc;
               if (win_ff[T_F] == win_ff[T_G]) qbl_in = nc;
               if (win_ff[T_H] == win_ff[T_C]) qtr_in = nc;
            end
         end
         CORNER_TR: begin
            nc = near_first ? win_ff[T_F] : win_ff[T_B];
            if (edge_hit) begin
               qtr_in = nc;
               if (win_ff[T_F] == win_ff[T_A]) qtl_in = nc;
               if (win_ff[T_B] == win_ff[T_I]) qbr_in = nc;
            end
         end
         CORNER_TL: begin
            nc = near_first ? win_ff[T_D] : win_ff[T_B];
            if (edge_hit) begin
               qtl_in = nc;
               if (win_ff[T_D] == win_ff[T_C]) qtr_in = nc;
               if (win_ff[T_B] == win_ff[T_G]) qbl_in = nc;
            end
         end
         default: begin
            nc = near_first ? win_ff[T_D] : win_ff[T_H];
            if (edge_hit) begin
               qbl_in = nc;
               if (win_ff[T_D] == win_ff[T_I]) qbr_in = nc;
               if (win_ff[T_H] == win_ff[T_A]) qtl_in = nc;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.issue && cmd.corner == CORNER_BR && cmd.sub == SUB_S1_FIRST) begin
         qtl_ff <= win_ff[T_E];
         qtr_ff <= win_ff[T_E];
         qbl_ff <= win_ff[T_E];
         qbr_ff <= win_ff[T_E];
      end else if (s3_v_ff && s3_sub_ff == SUB_LAST) begin
         qtl_ff <= qtl_in;
         qtr_ff <= qtr_in;
         qbl_ff <= qbl_in;
         qbr_ff <= qbr_in;
      end
   end

   // result register
   assign xw = WW'(col_ff) + WW'(cmd.xsel) - WW'(2);
   assign yw = row_ff - ROW_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.top_left      <= qtl_ff;
         rsp_ff.top_right     <= qtr_ff;
         rsp_ff.bottom_left   <= qbl_ff;
         rsp_ff.bottom_right  <= qbr_ff;
         rsp_ff.source_column <= 10'(xw);
         rsp_ff.source_row    <= yw[15:0];
         rsp_ff.last_in_step  <= cmd.out_last;
         rsp_ff.end_of_frame  <= (xw == eff_w - WW'(1)) && (yw == ROW_W'(eff_h) - ROW_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/xbr_ctrl.sv @@
// Controller: sequences column fetch, window update, distance issue and block output.
// Uses xbr_pkg; drives the datapath through xbr_cmd_type.
module xbr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  xbr_pkg::xbr_sts_type sts,
   output xbr_pkg::xbr_cmd_type cmd
);
   import xbr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_PASS  = 3'd6;
   localparam logic [2:0] S_STEP  = 3'd7;

   localparam logic [2:0] K_DONE = 3'(COL_TAPS);

   logic [2:0] state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [1:0] corner_ff, corner_in;
   logic [3:0] sub_ff, sub_in;
   logic [1:0] xsel_ff, xsel_in;
   logic       pass_ff, pass_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      corner_in = corner_ff;
      sub_in    = sub_ff;
      xsel_in   = xsel_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      cmd.rd_k  = k_ff;
      cmd.corner = corner_ff;
      cmd.sub   = sub_ff;
      cmd.xsel  = xsel_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = accept;
            if (accept && sts.kind_ok) begin
               state_in = S_READ;
               k_in     = '0;
            end
         end
         S_READ: begin
            cmd.rd_en = k_ff != K_DONE;
            if (k_ff == K_DONE) begin
               state_in = S_SHIFT;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         S_SHIFT: begin
            cmd.win_load = 1'b1;
            corner_in = CORNER_BR;
            sub_in    = SUB_S1_FIRST;
            if (sts.row_ge2 && sts.col_ge2) begin
               state_in = S_EMIT;
               xsel_in  = XSEL_LEFT2;
            end else if (sts.row_ge2 && sts.col_last) begin
               state_in = S_PASS;
               pass_in  = 1'b0;
            end else begin
               state_in = S_STEP;
            end
         end
         S_EMIT: begin
            cmd.issue = 1'b1;
            if (sub_ff == SUB_LAST) begin
               sub_in    = SUB_S1_FIRST;
               corner_in = corner_ff + 2'd1;
               if (corner_ff == CORNER_BL) begin
                  state_in = S_WAIT;
               end
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end
         S_WAIT: begin
            if (sts.emit_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               unique case (xsel_ff)
                  XSEL_LEFT2: begin
                     cmd.out_last = !sts.col_last;
                     state_in = sts.col_last ? S_PASS : S_STEP;
                     pass_in  = 1'b0;
                  end
                  XSEL_LEFT1: begin
                     cmd.out_last = 1'b0;
                     state_in = S_PASS;
                     pass_in  = 1'b1;
                  end
                  default: begin
                     cmd.out_last = 1'b1;
                     state_in = S_STEP;
                  end
               endcase
            end
         end
         S_PASS: begin
            cmd.win_pass = 1'b1;
            corner_in = CORNER_BR;
            sub_in    = SUB_S1_FIRST;
            if (pass_ff) begin
               state_in = S_EMIT;
               xsel_in  = XSEL_HERE;
            end else if (sts.col_ge1) begin
               state_in = S_EMIT;
               xsel_in  = XSEL_LEFT1;
            end else begin
               pass_in = 1'b1;
            end
         end
         default: begin
            cmd.step = 1'b1;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      corner_ff <= corner_in;
      sub_ff    <= sub_in;
      xsel_ff   <= xsel_in;
      pass_ff   <= pass_in;
   end

   // checks
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.emit_done |-> state_ff == S_WAIT)
      else $error("distance pipeline finished outside the wait state");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result register loaded while a block is still held");

   a_drop_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && !sts.kind_ok) |=> state_ff == S_IDLE)
      else $error("slot of the wrong kind started work");

endmodule

@@ rtl/xbr_2x_pixel_scaler_unit.sv @@
// 2x xBR pixel-art upscaler, top level. Source pixels stream in raster order; every source
// pixel yields one 2x2 block, two rows and two columns behind the input, and two flush rows of
// image_width slots (mode 1) drain the frame. Each item starts with a fetch and window update
// (five reads of the single-port-read line store), then for each block produced the 48 color
// distances of the four corner decisions go one per cycle through a shared pipelined distance
// unit. The last column of a row yields up to three blocks; a new item is taken only once the
// previous one is done. Writing image_width or image_height restarts the frame. Uses xbr_pkg,
// xbr_ctrl, xbr_datapath and xbr_ram.
module xbr_2x_pixel_scaler_unit #(
   parameter int MAX_WIDTH = xbr_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  xbr_pkg::xbr_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output xbr_pkg::xbr_rsp_type        rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [xbr_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import xbr_pkg::*;

   xbr_cmd_type cmd;
   xbr_sts_type sts;

   assign pready = 1'b1;

   xbr_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts(sts),
      .cmd(cmd)
   );

   xbr_datapath #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata)
   );

endmodule

@@ sim/tb.sv @@
// Testbench for the 2x xBR pixel scaler: directed frames, then random frames,
// checked block by block against a behavioral scaler. Depends on rtl/xbr_pkg.sv and the top level.
module tb;
   import xbr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXW = 1024;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   xbr_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   xbr_rsp_type rsp_data;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   xbr_2x_pixel_scaler_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scaler state mirrored here
   int unsigned width_reg = 1024, height_reg = 480;
   logic [31:0] lines [0:4*MAXW-1];
   logic [31:0] win [0:24];
   int unsigned col_pos = 0, row_pos = 0;
   xbr_rsp_type blocks_due[$];
   int errors = 0, beats_in = 0, beats_out = 0, frames = 0;
   int send_idle = 13, recv_idle = 68;
   bit hold_rsp = 1'b0;
   int quiet = 0;

   function automatic int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
   endfunction

   function automatic int unsigned eff_h();
      return (height_reg < 1) ? 1 : height_reg;
   endfunction

   function automatic int unsigned absd(int v);
      return (v < 0) ? -v : v;
   endfunction

   // YUV-weighted color distance in thousandths
   function automatic int unsigned color_dist(logic [31:0] p, logic [31:0] q);
      int r, g, b, a;
      r = absd(int'(p[7:0]) - int'(q[7:0]));
      g = absd(int'(p[15:8]) - int'(q[15:8]));
      b = absd(int'(p[23:16]) - int'(q[23:16]));
      a = absd(int'(p[31:24]) - int'(q[31:24]));
      return 48 * (299*r + 587*g + 114*b) + 7 * absd(-169*r - 331*g + 500*b)
         + 6 * absd(500*r - 419*g - 81*b) + 48000 * a;
   endfunction

   function automatic logic [31:0] tap(int i, int j);
      return win[i*5+j];
   endfunction

   function automatic void shift_window(logic [31:0] c [5]);
      for (int k = 0; k < 20; k++) win[k] = win[k+5];
      for (int k = 0; k < 5; k++) win[20+k] = c[k];
   endfunction

   // one 2x2 block from the current window
   function automatic xbr_rsp_type scale_block(int unsigned x, int unsigned y);
      xbr_rsp_type o;
      logic [31:0] a, b, c, d, e, f, g, h, i, a1, b1, c1, a0, c4, d0, f4, g0, i4, g5, h5, i5;
      logic [31:0] q0, q1, q2, q3, nc;
      int unsigned s1, s2;
      a = tap(1,1); b = tap(2,1); c = tap(3,1);
      d = tap(1,2); e = tap(2,2); f = tap(3,2);
      g = tap(1,3); h = tap(2,3); i = tap(3,3);
      a1 = tap(1,0); b1 = tap(2,0); c1 = tap(3,0);
      a0 = tap(0,1); c4 = tap(4,1); d0 = tap(0,2); f4 = tap(4,2);
      g0 = tap(0,3); i4 = tap(4,3); g5 = tap(1,4); h5 = tap(2,4); i5 = tap(3,4);
      q0 = e; q1 = e; q2 = e; q3 = e;
      // bottom-right
      s1 = color_dist(e,c) + color_dist(e,g) + color_dist(i,f4) + color_dist(i,h5)
         + 4*color_dist(h,f);
      s2 = color_dist(h,d) + color_dist(h,i5) + color_dist(f,i4) + color_dist(f,b)
         + 4*color_dist(e,i);
      if (s1 < s2) begin
         nc = (color_dist(e,f) <= color_dist(e,h)) ? f : h;
         q3 = nc;
         if (f == g) q2 = nc;
         if (h == c) q1 = nc;
      end
      // top-right
      s1 = color_dist(e,i) + color_dist(e,a) + color_dist(c,f4) + color_dist(c,b1)
         + 4*color_dist(b,f);
      s2 = color_dist(b,d) + color_dist(b,c1) + color_dist(f,h) + color_dist(f,c4)
         + 4*color_dist(e,c);
      if (s1 < s2) begin
         nc = (color_dist(e,f) <= color_dist(e,b)) ? f : b;
         q1 = nc;
         if (f == a) q0 = nc;
         if (b == i) q3 = nc;
      end
      // top-left
      s1 = color_dist(e,g) + color_dist(e,c) + color_dist(a,d0) + color_dist(a,b1)
         + 4*color_dist(b,d);
      s2 = color_dist(b,f) + color_dist(b,a1) + color_dist(d,h) + color_dist(d,a0)
         + 4*color_dist(e,a);
      if (s1 < s2) begin
         nc = (color_dist(e,d) <= color_dist(e,b)) ? d : b;
         q0 = nc;
         if (d == c) q1 = nc;
         if (b == g) q2 = nc;
      end
      // bottom-left
      s1 = color_dist(e,i) + color_dist(e,a) + color_dist(g,d0) + color_dist(g,h5)
         + 4*color_dist(h,d);
      s2 = color_dist(h,f) + color_dist(h,g5) + color_dist(d,b) + color_dist(d,g0)
         + 4*color_dist(e,g);
      if (s1 < s2) begin
         nc = (color_dist(e,d) <= color_dist(e,h)) ? d : h;
         q2 = nc;
         if (d == i) q3 = nc;
         if (h == a) q0 = nc;
      end
      o.top_left = q0; o.top_right = q1; o.bottom_left = q2; o.bottom_right = q3;
      o.source_column = x[9:0];
      o.source_row = y[15:0];
      o.last_in_step = 1'b0;
      o.end_of_frame = (x == eff_w() - 1 && y == eff_h() - 1);
      return o;
   endfunction

   // advance the mirrored scaler by one accepted beat
   function automatic void predict_slot(xbr_req_type it);
      int unsigned w, h, c, r, n;
      int jj;
      bit real_row;
      logic [31:0] column [5];
      xbr_rsp_type blk [$];
      w = eff_w(); h = eff_h();
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h + 2) row_pos = 0;
      c = col_pos; r = row_pos;
      real_row = r < h;
      if ((real_row && it.mode != MODE_PIXEL) || (!real_row && it.mode != MODE_FLUSH)) return;
      for (int k = 0; k < 5; k++) begin
         jj = int'(r) - 4 + k;
         if (jj < 0) jj = 0;
         if (jj > int'(h) - 1) jj = h - 1;
         if (real_row && jj == r) column[k] = it.pixel;
         else column[k] = lines[(jj % 4) * MAXW + c];
      end
      if (c == 0) begin
         for (int k = 0; k < 25; k++) win[k] = column[k % 5];
      end else begin
         shift_window(column);
      end
      if (real_row) lines[(r % 4) * MAXW + c] = it.pixel;
      if (r >= 2) begin
         if (c >= 2) blk.push_back(scale_block(c - 2, r - 2));
         if (c == w - 1) begin
            for (int p = 0; p < 2; p++) begin
               for (int k = 0; k < 5; k++) column[k] = win[20+k];
               shift_window(column);
               if (int'(c) - 1 + p >= 0) blk.push_back(scale_block(c - 1 + p, r - 2));
            end
         end
         n = blk.size();
         if (n > 0) blk[n-1].last_in_step = 1'b1;
         foreach (blk[k]) blocks_due.push_back(blk[k]);
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h + 2) row_pos = 0;
      end
   endfunction

   // output check, receiver stalls and watchdog
   always @(posedge clock) begin
      xbr_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (blocks_due.size() == 0) begin
               $error("unexpected block col %0d row %0d", rsp_data.source_column,
                  rsp_data.source_row);
               errors++;
            end else begin
               want = blocks_due.pop_front();
               if (want.top_left !== rsp_data.top_left) begin
                  $error("top_left exp %h got %h", want.top_left, rsp_data.top_left); errors++;
               end
               if (want.top_right !== rsp_data.top_right) begin
                  $error("top_right exp %h got %h", want.top_right, rsp_data.top_right); errors++;
               end
               if (want.bottom_left !== rsp_data.bottom_left) begin
                  $error("bottom_left exp %h got %h", want.bottom_left, rsp_data.bottom_left);
                  errors++;
               end
               if (want.bottom_right !== rsp_data.bottom_right) begin
                  $error("bottom_right exp %h got %h", want.bottom_right,
                     rsp_data.bottom_right);
                  errors++;
               end
               if (want.source_column !== rsp_data.source_column) begin
                  $error("source_column exp %0d got %0d", want.source_column,
                     rsp_data.source_column);
                  errors++;
               end
               if (want.source_row !== rsp_data.source_row) begin
                  $error("source_row exp %0d got %0d", want.source_row, rsp_data.source_row);
                  errors++;
               end
               if (want.last_in_step !== rsp_data.last_in_step) begin
                  $error("last_in_step exp %0d got %0d", want.last_in_step,
                     rsp_data.last_in_step);
                  errors++;
               end
               if (want.end_of_frame !== rsp_data.end_of_frame) begin
                  $error("end_of_frame exp %0d got %0d", want.end_of_frame,
                     rsp_data.end_of_frame);
                  errors++;
               end
            end
         end
         rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet > STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // one register write, setup then access
   task automatic csr_write(logic idx, logic [31:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_WIDTH) width_reg = val[10:0];
      else height_reg = val[15:0];
      col_pos = 0; row_pos = 0;
   endtask

   // offer one beat and wait for acceptance; prediction at the accepting edge
   // valid stays up after the beat and is lowered by whatever comes next
   task automatic send_slot(logic md, logic [31:0] px);
      xbr_req_type it;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      it.mode = md; it.pixel = px;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      predict_slot(it);
      beats_in++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (blocks_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pixel(int unsigned palette);
      // small palettes make equal neighbors, which exercises the corner rules
      case (palette)
         0: return $urandom();
         1: return ($urandom_range(1) != 0) ? 32'hFF00_00FF : 32'hFFFF_FFFF;
         default: return {$urandom_range(3) * 8'h55, $urandom_range(2) * 8'h7F,
            8'h00, $urandom_range(3) * 8'h55};
      endcase
   endfunction

   // a full frame including its two flush rows, with a few stray slots when noise is set
   task automatic run_frame(int unsigned w, int unsigned h, int unsigned palette, bit noise);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
      for (int r = 0; r < h + 2; r++) begin
         for (int c = 0; c < w; c++) begin
            if (noise && $urandom_range(9) == 0)
               send_slot((r < h) ? MODE_FLUSH : MODE_PIXEL, $urandom());
            send_slot((r < h) ? MODE_PIXEL : MODE_FLUSH,
               (r < h) ? rand_pixel(palette) : $urandom());
         end
      end
      frames++;
   endtask

   typedef struct {
      logic        md;
      logic [31:0] px;
   } slot_row_type;

   // directed: a 3x3 frame of extreme pixels, with misplaced slots
   slot_row_type directed [] = '{
      '{MODE_FLUSH, 32'hDEAD_BEEF},
      '{MODE_PIXEL, 32'h0000_0000}, '{MODE_PIXEL, 32'hFFFF_FFFF}, '{MODE_PIXEL, 32'h0000_0000},
      '{MODE_PIXEL, 32'hFFFF_FFFF}, '{MODE_PIXEL, 32'hFFFF_FFFF}, '{MODE_PIXEL, 32'h0000_0000},
      '{MODE_PIXEL, 32'hFF00_00FF}, '{MODE_PIXEL, 32'h00FF_FF00}, '{MODE_PIXEL, 32'h8080_8080},
      '{MODE_PIXEL, 32'h1234_5678},
      '{MODE_FLUSH, 32'h0}, '{MODE_FLUSH, 32'h0}, '{MODE_FLUSH, 32'h0},
      '{MODE_FLUSH, 32'h0}, '{MODE_FLUSH, 32'h0}, '{MODE_FLUSH, 32'hFFFF_FFFF}
   };

   // long receiver hold-off, counted here
   task automatic hold_receiver(int unsigned cycles);
      hold_rsp = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(REG_WIDTH, 3);
      csr_write(REG_HEIGHT, 3);
      foreach (directed[k]) send_slot(directed[k].md, directed[k].px);
      drain();

      // width 1 and height 0 (used as 1), then width 2
      run_frame(1, 0, 0, 1'b0); drain();
      run_frame(2, 1, 1, 1'b0); drain();

      // one frame at full width and height limits is far too long; forty pixels of
      // the first row at width 2047 (clamped to 1024) cover the wide setting
      csr_write(REG_HEIGHT, 16'hFFFF);
      csr_write(REG_WIDTH, 11'h7FF);
      for (int c = 0; c < 40; c++) send_slot(MODE_PIXEL, rand_pixel(0));
      drain();

      // receiver held off while the sender keeps offering
      fork
         hold_receiver(3000);
         run_frame(4, 3, 2, 1'b1);
      join
      drain();

      while (beats_in < 200) begin
         run_frame($urandom_range(3, 6), $urandom_range(1, 5), $urandom_range(2),
            $urandom_range(3) == 0);
         drain();
      end
      send_idle = 68; recv_idle = 13;
      while (beats_in < 270) begin
         run_frame($urandom_range(3, 6), $urandom_range(1, 4), $urandom_range(2), 1'b0);
         drain();
      end
      send_idle = 0; recv_idle = 0;
      while (beats_in < 320) begin
         run_frame($urandom_range(3, 6), $urandom_range(1, 4), $urandom_range(2), 1'b0);
         drain();
      end

      $display("Covered %0d frames, %0d input beats, %0d blocks checked,", frames, beats_in,
         beats_out);
      $display("widths 1..2047 and heights 0..65535 with stray slots and long stalls.");
      if (errors == 0 && blocks_due.size() == 0) begin
         $display("PASS");
      end else begin
         if (blocks_due.size() != 0) $error("%0d blocks never came", blocks_due.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/xbr_pkg.sv
rtl/xbr_ram.sv
rtl/xbr_datapath.sv
rtl/xbr_ctrl.sv
rtl/xbr_2x_pixel_scaler_unit.sv
sim/tb.sv
